### rtl/mlrf_pkg.sv
// shared constants, types and width helpers for the regression forecast block
`default_nettype none

package mlrf_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 32;
	localparam int CFG_W = 7;
	localparam int OUT_W = 48;
	// quotient bits kept by the divider: one above the output range to see overflow
	localparam int Q_W = OUT_W + 1;

	// defaults for the top level parameters
	localparam int DEF_MAX_WINDOW = 64;
	localparam int DEF_FRAC_BITS = 16;

	localparam int MIN_WINDOW = 2;
	localparam logic [CFG_W-1:0] WL_RESET = CFG_W'(14);

	// job queue depth between front and back, a power of two
	localparam int QUEUE_DEPTH = 2;

	// saturation limits as quotient magnitudes
	localparam logic [Q_W-1:0] POS_LIM = Q_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [Q_W-1:0] NEG_LIM = Q_W'(64'd1 << (OUT_W - 1));

	typedef enum logic {
		F_IDLE,
		F_UPD
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_ABS,
		B_PREP,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		C_RUN,
		C_PROD,
		C_DIFF,
		C_DONE
	} cst_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// width of a window length value
	function automatic int n_w(input int mw);
		return $clog2(mw + 1);
	endfunction

	// width of a ring slot index
	function automatic int slot_w(input int mw);
		return $clog2(mw);
	endfunction

	// width of sum of x for the largest window
	function automatic int sx_w(input int mw);
		return $clog2(longint'(mw) * (mw + 1) / 2 + 1);
	endfunction

	// width of sum of x squared for the largest window
	function automatic int sxx_w(input int mw);
		return $clog2(longint'(mw) * (mw + 1) * (2 * mw + 1) / 6 + 1);
	endfunction

	// width of the squares counter
	function automatic int sq_w(input int mw);
		return $clog2(longint'(mw) * mw + 1);
	endfunction

	// width of the regression denominator
	function automatic int den_w(input int mw);
		return $clog2(longint'(mw) * mw * (longint'(mw) * mw - 1) / 12 + 1);
	endfunction

	// signed width of the running sum of samples
	function automatic int sy_w(input int mw);
		return SAMPLE_W + $clog2(mw);
	endfunction

	// signed width of the weighted sum of samples
	function automatic int sxy_w(input int mw);
		return SAMPLE_W + sx_w(mw) + 1;
	endfunction

	// signed width of the regression numerator
	function automatic int num_w(input int mw);
		int a;
		int b;
		a = sxx_w(mw) + sy_w(mw);
		b = sx_w(mw) + sxy_w(mw);
		return ((a > b) ? a : b) + 1;
	endfunction

endpackage

`default_nettype wire

### rtl/mlrf_in_if.sv
// sample channel: valid, ready and one signed sample
`default_nettype none

interface mlrf_in_if
	import mlrf_pkg::*;
();
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

`default_nettype wire

### rtl/mlrf_out_if.sv
// forecast channel: valid, ready, forecast value and its valid flag
`default_nettype none

interface mlrf_out_if
	import mlrf_pkg::*;
();
	logic valid;
	logic ready;
	logic signed [OUT_W-1:0] forecast;
	logic forecast_valid;

	modport source(output valid, output forecast, output forecast_valid, input ready);
	modport sink(input valid, input forecast, input forecast_valid, output ready);
endinterface

`default_nettype wire

### rtl/moving_linear_regression_forecast.sv
// top level of the moving linear regression forecast block
// a forecast is made by the bit-serial numerator over K multiplier bits and the
//   one-bit-per-cycle divider over Q_W quotient bits, K = width of the largest sum
//   of x squared (17 at 64 samples), Q_W = 49; an invalid result skips both
// the front takes new samples while the back end works, until the job queue is full
// reset and each window_length write empty the window; the per-length constants are
//   then rebuilt, and no forecast is computed before they are ready
`default_nettype none

module moving_linear_regression_forecast
	import mlrf_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	mlrf_in_if.sink          in_ch,
	mlrf_out_if.source       out_ch
);

	localparam int N_W = n_w(MAX_WINDOW);
	localparam int SY_W = sy_w(MAX_WINDOW);
	localparam int SXY_W = sxy_w(MAX_WINDOW);
	localparam int SX_W = sx_w(MAX_WINDOW);
	localparam int SXX_W = sxx_w(MAX_WINDOW);
	localparam int DEN_W = den_w(MAX_WINDOW);
	localparam int E_W = 1 + SY_W + SXY_W;
	localparam int EW = (CFG_W > N_W) ? CFG_W : N_W;

	logic [CFG_W-1:0] wl_q;
	logic [EW-1:0] wl_ext;
	logic [N_W-1:0] n_eff;
	logic q_push, q_pop;
	q_status_t q_stat;
	logic [E_W-1:0] q_wdata, q_rdata;
	logic job_go_f, job_go_b;
	logic signed [SY_W-1:0] job_sy_f, job_sy_b;
	logic signed [SXY_W-1:0] job_sxy_f, job_sxy_b;
	logic [SX_W-1:0] cst_sx;
	logic [SXX_W-1:0] cst_sxx;
	logic [DEN_W-1:0] cst_den;
	logic cst_ready;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WL_RESET;
		end else if (cfg_we) begin
			wl_q <= cfg_wdata;
		end
	end

	// clamp the length into the supported range
	assign wl_ext = EW'(wl_q);
	always_comb begin
		priority if (wl_ext < EW'(MIN_WINDOW)) begin
			n_eff = N_W'(MIN_WINDOW);
		end else if (wl_ext > EW'(MAX_WINDOW)) begin
			n_eff = N_W'(MAX_WINDOW);
		end else begin
			n_eff = N_W'(wl_ext);
		end
	end

	mlrf_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_clear(cfg_we),
		.n        (n_eff),
		.in_ch    (in_ch),
		.q_full   (q_stat.full),
		.push     (q_push),
		.job_go   (job_go_f),
		.job_sy   (job_sy_f),
		.job_sxy  (job_sxy_f)
	);

	assign q_wdata = {job_go_f, job_sy_f, job_sxy_f};

	mlrf_queue #(
		.WIDTH(E_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.status(q_stat)
	);

	assign job_go_b = q_rdata[E_W-1];
	assign job_sy_b = q_rdata[E_W-2 -: SY_W];
	assign job_sxy_b = q_rdata[SXY_W-1:0];

	mlrf_const #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_const (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_we),
		.n      (n_eff),
		.sx     (cst_sx),
		.sxx    (cst_sxx),
		.den    (cst_den),
		.ready  (cst_ready)
	);

	mlrf_back #(
		.MAX_WINDOW(MAX_WINDOW),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_stat.empty),
		.pop      (q_pop),
		.job_go   (job_go_b),
		.job_sy   (job_sy_b),
		.job_sxy  (job_sxy_b),
		.sx       (cst_sx),
		.sxx      (cst_sxx),
		.den      (cst_den),
		.cst_ready(cst_ready),
		.out_ch   (out_ch)
	);

`ifndef SYNTHESIS
	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job pushed into full queue");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job popped from empty queue");

	// jobs start only with valid per-length constants
	a_cst_before_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cst_ready)
		else $error("job started before constants were ready");

	// a length write invalidates the constants
	a_cst_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !cst_ready)
		else $error("constants still marked ready after length write");
`endif

endmodule

`default_nettype wire

### rtl/mlrf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module mlrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/mlrf_front.sv
// front end: takes samples, keeps the ring and running sums, queues forecast jobs
`default_nettype none

module mlrf_front
	import mlrf_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_clear,
	input  logic [n_w(MAX_WINDOW)-1:0]              n,
	mlrf_in_if.sink                                 in_ch,
	input  logic                                    q_full,
	output logic                                    push,
	output logic                                    job_go,
	output logic signed [sy_w(MAX_WINDOW)-1:0]      job_sy,
	output logic signed [sxy_w(MAX_WINDOW)-1:0]     job_sxy
);

	localparam int N_W = n_w(MAX_WINDOW);
	localparam int SLOT_W = slot_w(MAX_WINDOW);
	localparam int SY_W = sy_w(MAX_WINDOW);
	localparam int SXY_W = sxy_w(MAX_WINDOW);
	localparam int PR_W = SAMPLE_W + N_W + 2;

	front_state_t state_q, state_d;
	logic accept;
	logic [SLOT_W-1:0] slot_q, slot, slot_next;
	logic [N_W:0] slot_inc, n_ext, n_inc;
	logic [N_W-1:0] fill_q, fill_new;
	logic signed [SY_W-1:0] sy_q, sy_new;
	logic signed [SXY_W-1:0] sxy_q, sxy_new, sxy_base;
	logic signed [SAMPLE_W-1:0] sample_s1, oldest;
	logic full_s1;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic signed [PR_W-1:0] old_prod;

	assign in_ch.ready = (state_q == F_IDLE) && !q_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign push = (state_q == F_UPD);

	// slot addressing, wrapping at the window length
	assign n_ext = (N_W+1)'(n);
	assign slot = ((N_W+1)'(slot_q) >= n_ext) ? '0 : slot_q;
	assign slot_inc = (N_W+1)'(slot) + (N_W+1)'(1);
	assign slot_next = (slot_inc >= n_ext) ? '0 : slot_inc[SLOT_W-1:0];

	mlrf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(slot),
		.wdata(in_ch.sample),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	// sum update with the sample that leaves the window
	assign oldest = $signed(ram_rdata);
	assign n_inc = n_ext + (N_W+1)'(1);
	assign old_prod = oldest * $signed({1'b0, n_inc});
	assign sxy_base = sxy_q + SXY_W'(sy_q) + SXY_W'(sample_s1);

	always_comb begin
		if (full_s1) begin
			sxy_new = sxy_base - SXY_W'(old_prod);
			sy_new = sy_q + SY_W'(sample_s1) - SY_W'(oldest);
			fill_new = fill_q;
		end else begin
			sxy_new = sxy_base;
			sy_new = sy_q + SY_W'(sample_s1);
			fill_new = fill_q + N_W'(1);
		end
	end

	assign job_go = (fill_new >= n) && (sy_new != '0) && (sxy_new != '0);
	assign job_sy = sy_new;
	assign job_sxy = sxy_new;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_UPD;
			F_UPD:  state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window state, emptied by a length write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sy_q <= '0;
			sxy_q <= '0;
		end else if (cfg_clear) begin
			slot_q <= '0;
			fill_q <= '0;
			sy_q <= '0;
			sxy_q <= '0;
		end else begin
			if (accept) slot_q <= slot_next;
			if (push) begin
				fill_q <= fill_new;
				sy_q <= sy_new;
				sxy_q <= sxy_new;
			end
		end
	end

	// item held for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_ch.sample;
			full_s1 <= (fill_q >= n);
		end
	end

endmodule

`default_nettype wire

### rtl/mlrf_queue.sv
// short job queue between front and back end
`default_nettype none

module mlrf_queue
	import mlrf_pkg::*;
#(
	parameter int WIDTH = 84
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output q_status_t        status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign rdata = mem_q[rd_ptr_q];
	assign status.full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/mlrf_const.sv
// per-length constants: sum of x, sum of x squared and the denominator
`default_nettype none

module mlrf_const
	import mlrf_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [n_w(MAX_WINDOW)-1:0]   n,
	output logic [sx_w(MAX_WINDOW)-1:0]  sx,
	output logic [sxx_w(MAX_WINDOW)-1:0] sxx,
	output logic [den_w(MAX_WINDOW)-1:0] den,
	output logic                         ready
);

	localparam int N_W = n_w(MAX_WINDOW);
	localparam int SX_W = sx_w(MAX_WINDOW);
	localparam int SXX_W = sxx_w(MAX_WINDOW);
	localparam int SQ_W = sq_w(MAX_WINDOW);
	localparam int DEN_W = den_w(MAX_WINDOW);
	localparam int P_W = ((N_W + SXX_W) > (2 * SX_W)) ? (N_W + SXX_W) : (2 * SX_W);

	cst_state_t state_q, state_d;
	logic [N_W-1:0] k_q;
	logic [SQ_W-1:0] sq_q, sq_next;
	logic [SX_W-1:0] sx_q;
	logic [SXX_W-1:0] sxx_q;
	logic [N_W+SXX_W-1:0] p1_full;
	logic [2*SX_W-1:0] p2_full;
	logic [P_W-1:0] p1_q, p2_q;
	logic [DEN_W-1:0] den_q;

	assign sq_next = sq_q + SQ_W'({k_q, 1'b1});
	assign p1_full = n * sxx_q;
	assign p2_full = sx_q * sx_q;

	assign sx = sx_q;
	assign sxx = sxx_q;
	assign den = den_q;
	assign ready = (state_q == C_DONE);

	// next state: accumulate n terms, two products, one difference
	always_comb begin
		state_d = state_q;
		priority if (restart) begin
			state_d = C_RUN;
		end else begin
			unique case (state_q)
				C_RUN:  if (k_q == n) state_d = C_PROD;
				C_PROD: state_d = C_DIFF;
				C_DIFF: state_d = C_DONE;
				C_DONE: state_d = C_DONE;
				default: state_d = C_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// running sums over k = 1..n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			sq_q <= '0;
			sx_q <= '0;
			sxx_q <= '0;
		end else if (restart) begin
			k_q <= '0;
			sq_q <= '0;
			sx_q <= '0;
			sxx_q <= '0;
		end else if ((state_q == C_RUN) && (k_q != n)) begin
			k_q <= k_q + N_W'(1);
			sq_q <= sq_next;
			sx_q <= sx_q + SX_W'(k_q) + SX_W'(1);
			sxx_q <= sxx_q + SXX_W'(sq_next);
		end
	end

	// denominator n*sxx - sx*sx
	always_ff @(posedge clk) begin
		if (state_q == C_PROD) begin
			p1_q <= P_W'(p1_full);
			p2_q <= P_W'(p2_full);
		end
		if (state_q == C_DIFF) begin
			den_q <= DEN_W'(p1_q - p2_q);
		end
	end

endmodule

`default_nettype wire

### rtl/mlrf_back.sv
// back end: serial numerator, restoring divider, rounding, saturation, output register
`default_nettype none

module mlrf_back
	import mlrf_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	output logic                                  pop,
	input  logic                                  job_go,
	input  logic signed [sy_w(MAX_WINDOW)-1:0]    job_sy,
	input  logic signed [sxy_w(MAX_WINDOW)-1:0]   job_sxy,
	input  logic [sx_w(MAX_WINDOW)-1:0]           sx,
	input  logic [sxx_w(MAX_WINDOW)-1:0]          sxx,
	input  logic [den_w(MAX_WINDOW)-1:0]          den,
	input  logic                                  cst_ready,
	mlrf_out_if.source                            out_ch
);

	localparam int SY_W = sy_w(MAX_WINDOW);
	localparam int SXY_W = sxy_w(MAX_WINDOW);
	localparam int K = sxx_w(MAX_WINDOW);
	localparam int DEN_W = den_w(MAX_WINDOW);
	localparam int NUM_W = num_w(MAX_WINDOW);
	localparam int DV_W = DEN_W + 1;
	localparam int X_W = ((NUM_W + FRAC_BITS + 2) > (Q_W + 1)) ?
		(NUM_W + FRAC_BITS + 2) : (Q_W + 1);
	localparam int H_W = X_W - Q_W;
	localparam int CMP_W = (H_W > DV_W) ? H_W : DV_W;
	localparam int CNT_W = $clog2(((K > Q_W) ? K : Q_W) + 1);

	back_state_t state_q, state_d;
	logic go_q, neg_q, ovf_q;
	logic signed [SY_W-1:0] sy_q;
	logic signed [SXY_W-1:0] sxy_q;
	logic [K-1:0] sxx_sh_q, sx_sh_q;
	logic signed [NUM_W-1:0] acc_q, acc_step, add_y, sub_xy;
	logic [CNT_W-1:0] cnt_q;
	logic [DV_W-1:0] dv, rem_q;
	logic [Q_W-1:0] lo_q, lo_neg;
	logic [X_W-1:0] xv;
	logic [DV_W:0] trial;
	logic trial_ge;
	logic load_out;
	logic out_valid_q;
	logic signed [OUT_W-1:0] forecast_q, res;
	logic fvalid_q;

	assign pop = (state_q == B_IDLE) && !q_empty && cst_ready;
	assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ch.ready);

	// one multiplier bit of sxx*sy - sx*sxy per cycle, msb first
	assign add_y = sxx_sh_q[K-1] ? NUM_W'(sy_q) : '0;
	assign sub_xy = sx_sh_q[K-1] ? NUM_W'(sxy_q) : '0;
	assign acc_step = (acc_q <<< 1) + add_y - sub_xy;

	// dividend |num|*2^(F+1) + den over divisor 2*den gives the rounded quotient
	assign dv = {den, 1'b0};
	assign xv = (X_W'($unsigned(acc_q)) << (FRAC_BITS + 1)) + X_W'(den);

	// restoring divide step
	assign trial = {rem_q, lo_q[Q_W-1]};
	assign trial_ge = (trial >= (DV_W+1)'(dv));

	// rounding done, clamp the signed result
	assign lo_neg = ~lo_q + Q_W'(1);
	always_comb begin
		priority if (!go_q) begin
			res = '0;
		end else if (neg_q) begin
			if (ovf_q || (lo_q > NEG_LIM)) res = NEG_LIM[OUT_W-1:0];
			else res = lo_neg[OUT_W-1:0];
		end else begin
			if (ovf_q || (lo_q > POS_LIM)) res = POS_LIM[OUT_W-1:0];
			else res = lo_q[OUT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (pop) state_d = job_go ? B_MUL : B_OUT;
			B_MUL:  if (cnt_q == CNT_W'(1)) state_d = B_ABS;
			B_ABS:  state_d = B_PREP;
			B_PREP: state_d = B_DIV;
			B_DIV:  if (cnt_q == CNT_W'(1)) state_d = B_OUT;
			B_OUT:  if (load_out) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			cnt_q <= CNT_W'(K);
		end else if (state_q == B_PREP) begin
			cnt_q <= CNT_W'(Q_W);
		end else if ((state_q == B_MUL) || (state_q == B_DIV)) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					go_q <= job_go;
					sy_q <= job_sy;
					sxy_q <= job_sxy;
					sxx_sh_q <= sxx;
					sx_sh_q <= K'(sx);
					acc_q <= '0;
				end
			end
			B_MUL: begin
				acc_q <= acc_step;
				sxx_sh_q <= sxx_sh_q << 1;
				sx_sh_q <= sx_sh_q << 1;
			end
			B_ABS: begin
				neg_q <= acc_q[NUM_W-1];
				if (acc_q[NUM_W-1]) acc_q <= -acc_q;
			end
			B_PREP: begin
				ovf_q <= (CMP_W'(xv[X_W-1:Q_W]) >= CMP_W'(dv));
				rem_q <= DV_W'(xv[X_W-1:Q_W]);
				lo_q <= xv[Q_W-1:0];
			end
			B_DIV: begin
				rem_q <= trial_ge ? DV_W'(trial - (DV_W+1)'(dv)) : DV_W'(trial);
				lo_q <= {lo_q[Q_W-2:0], trial_ge};
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			forecast_q <= res;
			fvalid_q <= go_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.forecast = forecast_q;
	assign out_ch.forecast_valid = fvalid_q;

endmodule

`default_nettype wire

### sim/moving_linear_regression_forecast_tb.sv
// testbench for the moving linear regression forecast block: directed table, then random phases
`default_nettype none

module moving_linear_regression_forecast_tb;
	import mlrf_pkg::*;

	localparam int FRAC = DEF_FRAC_BITS;
	localparam int WMAX = DEF_MAX_WINDOW;
	localparam logic [63:0] FC_POS_MAX = (64'd1 << (OUT_W - 1)) - 64'd1;
	localparam logic [63:0] FC_NEG_MAX = 64'd1 << (OUT_W - 1);
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 150;
	localparam int CALM_AFTER = 1450;
	localparam int DRAIN_CYCLES = 90;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic signed [OUT_W-1:0] fc;
		logic fv;
	} forecast_t;

	// one row of the directed table: a length write or a sample with an optional known result
	typedef struct packed {
		logic wr;
		logic [CFG_W-1:0] wl;
		logic signed [SAMPLE_W-1:0] smp;
		logic known;
		logic signed [OUT_W-1:0] fc;
		logic fv;
	} step_row_t;

	localparam int ROWS = 23;
	localparam step_row_t DIRECTED [ROWS] = '{
		// default length of 14, still filling
		'{1'b0, 7'd0, 32'h0000_0000, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h7fff_ffff, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h8000_0000, 1'b1, 48'h0, 1'b0},
		// two samples: forecast is 2*newest - older
		'{1'b1, 7'd2, 32'h0, 1'b0, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0001, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0002, 1'b1, 48'd196608, 1'b1},
		// saturation both ways
		'{1'b0, 7'd0, 32'h8000_0000, 1'b1, 48'h8000_0000_0000, 1'b1},
		'{1'b0, 7'd0, 32'h7fff_ffff, 1'b1, 48'h7fff_ffff_ffff, 1'b1},
		'{1'b0, 7'd0, 32'h0000_0000, 1'b0, 48'h0, 1'b0},
		// both sums zero, then only the plain sum zero, then only the weighted sum zero
		'{1'b0, 7'd0, 32'h0000_0000, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0005, 1'b0, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'hffff_fffb, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_000a, 1'b1, 48'h0, 1'b0},
		// lengths below the minimum act as two
		'{1'b1, 7'd0, 32'h0, 1'b0, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0007, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'hffff_fffd, 1'b0, 48'h0, 1'b0},
		'{1'b1, 7'd1, 32'h0, 1'b0, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0004, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0004, 1'b0, 48'h0, 1'b0},
		// three samples, fractional rounding
		'{1'b1, 7'd3, 32'h0, 1'b0, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0001, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'hffff_ffff, 1'b1, 48'h0, 1'b0},
		'{1'b0, 7'd0, 32'h0000_0001, 1'b0, 48'h0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	mlrf_in_if in_ch ();
	mlrf_out_if out_ch ();

	moving_linear_regression_forecast i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// shadow state of the regression window
	logic [CFG_W-1:0] wl_reg;
	logic signed [SAMPLE_W-1:0] ring_mem [WMAX];
	int unsigned slot_ptr;
	int unsigned fill_n;
	longint sum_y;
	longint sum_xy;

	forecast_t forecast_q [$];
	int fail_count;
	int sent_count;
	bit calm;

	always #5 clk = ~clk;

	// predicted forecasts in order, oldest first
	function automatic void note_forecast(input forecast_t f);
		forecast_q.insert(forecast_q.size(), f);
	endfunction

	function automatic forecast_t take_forecast();
		forecast_t f;
		f = forecast_q[0];
		forecast_q.delete(0);
		return f;
	endfunction

	// length write empties the window
	function automatic void set_length(input logic [CFG_W-1:0] v);
		wl_reg = v;
		slot_ptr = 0;
		fill_n = 0;
		sum_y = 0;
		sum_xy = 0;
	endfunction

	// advance the window by one sample and work out the forecast
	function automatic forecast_t predict_forecast(input logic signed [SAMPLE_W-1:0] s);
		forecast_t res;
		int unsigned slot;
		longint nn, v, oldest, sx, sxx, den, num;
		logic [63:0] mag, d, q, r, m;
		bit neg;
		nn = (wl_reg < MIN_WINDOW) ? MIN_WINDOW : ((wl_reg > WMAX) ? WMAX : longint'(wl_reg));
		v = longint'(s);
		slot = (slot_ptr >= nn) ? 0 : slot_ptr;
		if (fill_n < nn) begin
			sum_xy += sum_y + v;
			sum_y += v;
			fill_n++;
		end else begin
			oldest = longint'(ring_mem[slot]);
			sum_xy += sum_y + v - oldest * (nn + 1);
			sum_y += v - oldest;
		end
		ring_mem[slot] = s;
		slot_ptr = (slot + 1 >= nn) ? 0 : slot + 1;
		res.fc = '0;
		res.fv = 1'b0;
		if (fill_n >= nn && sum_y != 0 && sum_xy != 0) begin
			sx = nn * (nn + 1) / 2;
			sxx = nn * (nn + 1) * (2 * nn + 1) / 6;
			den = nn * sxx - sx * sx;
			num = sxx * sum_y - sx * sum_xy;
			neg = num < 0;
			mag = neg ? 64'd0 - 64'(num) : 64'(num);
			d = 64'(den);
			q = mag / d;
			r = mag % d;
			// quotient far past the range: clamp, no rounding needed
			if (q > (FC_POS_MAX >> FRAC) + 64'd1)
				m = FC_NEG_MAX + 64'd1;
			else
				m = (q << FRAC) + (((r << FRAC) * 64'd2 + d) / (64'd2 * d));
			if (neg) begin
				if (m > FC_NEG_MAX)
					m = FC_NEG_MAX;
				res.fc = OUT_W'(64'd0 - m);
			end else begin
				if (m > FC_POS_MAX)
					m = FC_POS_MAX;
				res.fc = OUT_W'(m);
			end
			res.fv = 1'b1;
		end
		return res;
	endfunction

	// random sample of several flavors, some built on the previous one
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
		input logic signed [SAMPLE_W-1:0] prev
	);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4: return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
			6: return '0;
			7: return 32'd0 - prev;
			8: return prev + SAMPLE_W'(int'($urandom_range(0, 20)) - 10);
			default: return ($urandom & 32'h0000_ffff) |
				($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_0000);
		endcase
	endfunction

	// offer one item from a falling edge, record its forecast on acceptance
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int gap,
		input bit known, input forecast_t given);
		forecast_t want;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		do @(posedge clk); while (!in_ch.ready);
		want = predict_forecast(s);
		note_forecast(known ? given : want);
		sent_count++;
		@(negedge clk);
	endtask

	// stop offering and let every forecast come back, then the block settles
	task automatic drain_block();
		in_ch.valid <= 1'b0;
		while (forecast_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		set_length(v);
	endtask

	// sender gap: bursts of idle cycles unless the phase is busy or the run is calm
	function automatic int pick_gap(input bit busy);
		if (calm || busy || $urandom_range(0, 4) != 0)
			return 0;
		return $urandom_range(1, 18);
	endfunction

	// stimulus
	initial begin
		step_row_t row;
		forecast_t given;
		logic signed [SAMPLE_W-1:0] prev;
		logic [CFG_W-1:0] wl_pick;
		bit busy;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		fail_count = 0;
		sent_count = 0;
		calm = 1'b0;
		prev = '0;
		set_length(WL_RESET);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < ROWS; i++) begin
			row = DIRECTED[i];
			if (row.wr) begin
				drain_block();
				write_length(row.wl);
			end else begin
				given.fc = row.fc;
				given.fv = row.fv;
				send_sample(row.smp, pick_gap(1'b0), row.known, given);
			end
		end

		// random phases over several lengths, extremes first
		given = '0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: wl_pick = 7'd64;
				1: wl_pick = 7'd127;
				2: wl_pick = 7'd2;
				3: wl_pick = 7'd65;
				4: wl_pick = 7'd0;
				5: wl_pick = 7'd1;
				6: wl_pick = 7'd3;
				7: wl_pick = WL_RESET;
				default: wl_pick = CFG_W'($urandom_range(0, 127));
			endcase
			drain_block();
			write_length(wl_pick);
			busy = $urandom_range(0, 2) == 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (sent_count >= ROWS + CALM_AFTER)
					calm = 1'b1;
				prev = pick_sample(prev);
				send_sample(prev, pick_gap(busy), 1'b0, given);
			end
		end

		// wind down
		drain_block();
		if (fail_count == 0 && forecast_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver: random stall bursts, stretches of steady ready, one long hold-off
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && sent_count >= HOLD_AT) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// compare each forecast item with the oldest one predicted
	always @(posedge clk) begin : check_forecast
		forecast_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (forecast_q.size() == 0) begin
				$error("forecast item with none expected");
				fail_count++;
			end else begin
				want = take_forecast();
				if (out_ch.forecast !== want.fc) begin
					$error("forecast: expected %0d, got %0d", want.fc, out_ch.forecast);
					fail_count++;
				end
				if (out_ch.forecast_valid !== want.fv) begin
					$error("forecast_valid: expected %0d, got %0d", want.fv,
						out_ch.forecast_valid);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
